@@ rtl/lisr_pkg.sv @@
// ----------------------------------------------------------------------------
// lisr_pkg: shared types and constants of the stereo linear resampler
// Widths, rate limits, configuration register indexes, controller states
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lisr_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int RATE_W          = 18;
  localparam int RATE_MIN        = 8000;
  localparam int RATE_MAX        = 192000;
  localparam int RATE_RESET      = 48000;
  localparam int SOURCE_RATE_DEF = 32000;
  localparam int MAX_RESULTS     = 6;
  localparam int CNT_W           = $clog2(MAX_RESULTS + 1);
  localparam int STEP_W          = $clog2(SAMPLE_W);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE        = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PR_EMPTY,
    PR_ONE,
    PR_FULL
  } prime_t;

  typedef struct packed {
    logic load;       // take the input frame, update frames and phase
    logic mul;        // form |newer - older| * phase in both lanes
    logic div_step;   // one restoring division step in both lanes
    logic emit;       // write the result register, advance the phase
    logic emit_last;  // the written result closes this input's run
  } cmd_t;

  typedef struct packed {
    logic primed0;    // no frame held yet
    logic more;       // phase below rate
    logic last_hint;  // phase plus source rate reaches rate
    logic out_free;   // result register can take a new item
  } sts_t;

endpackage

@@ rtl/lisr_lane.sv @@
// ----------------------------------------------------------------------------
// lisr_lane: one channel of the interpolator
// Registered magnitude multiply, then a restoring divider that retires one
// quotient bit per step; the signed quotient is added to the older sample.
// ----------------------------------------------------------------------------
module lisr_lane (
  input  logic                          clk,
  input  logic                          mul_en,
  input  logic                          step_en,
  input  logic                          mute,
  input  logic [lisr_pkg::SAMPLE_W-1:0] older,
  input  logic [lisr_pkg::SAMPLE_W-1:0] newer,
  input  logic [lisr_pkg::RATE_W-1:0]   phase,
  input  logic [lisr_pkg::RATE_W-1:0]   divisor,
  output logic [lisr_pkg::SAMPLE_W-1:0] sample
);

  localparam int SW = lisr_pkg::SAMPLE_W;
  localparam int RW = lisr_pkg::RATE_W;

  logic [SW:0]    diff;
  logic [SW:0]    diff_neg;
  logic [SW-1:0]  mag;
  logic [SW+RW-1:0] prod;
  logic [RW:0]    trial;
  logic [RW:0]    trial_sub;
  logic           fits;
  logic [SW:0]    quo_ext;
  logic [SW:0]    quo_s;
  logic [SW:0]    sum;

  logic           sign_r;
  logic [RW-1:0]  rem_r;
  logic [SW-1:0]  quo_r;

  assign diff     = {newer[SW-1], newer} - {older[SW-1], older};
  assign diff_neg = '0 - diff;
  assign mag      = diff[SW] ? diff_neg[SW-1:0] : diff[SW-1:0];
  assign prod     = (SW+RW)'(mag) * (SW+RW)'(phase);

  // the quotient stays below 2**SW, so the upper product bits start below the divisor
  assign trial     = {rem_r, quo_r[SW-1]};
  assign fits      = trial >= {1'b0, divisor};
  assign trial_sub = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (mul_en) begin
      sign_r <= diff[SW];
      rem_r  <= prod[SW+RW-1:SW];
      quo_r  <= prod[SW-1:0];
    end else if (step_en) begin
      rem_r  <= fits ? trial_sub[RW-1:0] : trial[RW-1:0];
      quo_r  <= {quo_r[SW-2:0], fits};
    end
  end

  assign quo_ext = {1'b0, quo_r};
  assign quo_s   = sign_r ? ('0 - quo_ext) : quo_ext;
  assign sum     = {older[SW-1], older} + quo_s;
  assign sample  = mute ? '0 : sum[SW-1:0];

endmodule

@@ rtl/lisr_dp.sv @@
// ----------------------------------------------------------------------------
// lisr_dp: resampler datapath
// Frame pair, phase accumulator, priming state, two interpolation lanes
// and the result register.
// ----------------------------------------------------------------------------
module lisr_dp #(
  parameter int SOURCE_RATE = lisr_pkg::SOURCE_RATE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lisr_pkg::cmd_t                cmd,
  input  logic [lisr_pkg::SAMPLE_W-1:0] in_right,
  input  logic [lisr_pkg::SAMPLE_W-1:0] in_left,
  input  logic [lisr_pkg::RATE_W-1:0]   rate,
  input  logic                          mute,
  input  logic                          out_ready,
  output lisr_pkg::sts_t                sts,
  output logic                          out_valid,
  output logic [lisr_pkg::SAMPLE_W-1:0] out_left,
  output logic [lisr_pkg::SAMPLE_W-1:0] out_right,
  output logic                          out_last
);

  localparam int SW = lisr_pkg::SAMPLE_W;
  localparam int RW = lisr_pkg::RATE_W;
  localparam int PW = $clog2(lisr_pkg::RATE_MAX + SOURCE_RATE);
  localparam logic [PW:0] SR_EXT = (PW+1)'(SOURCE_RATE);

  lisr_pkg::prime_t primed_r;
  logic [PW-1:0]    phase_r;
  logic             out_valid_r;
  logic [SW-1:0]    older_r_r, older_l_r, newer_r_r, newer_l_r;
  logic [SW-1:0]    out_left_r, out_right_r;
  logic             out_last_r;

  logic [PW-1:0]    rate_ext;
  logic [PW-1:0]    phase_sub;
  logic [PW:0]      phase_sum;
  logic [SW-1:0]    lane_l, lane_r;

  assign rate_ext  = PW'(rate);
  assign phase_sub = (phase_r >= rate_ext) ? phase_r - rate_ext : '0;
  assign phase_sum = {1'b0, phase_r} + SR_EXT;

  assign sts.primed0   = primed_r == lisr_pkg::PR_EMPTY;
  assign sts.more      = phase_r < rate_ext;
  assign sts.last_hint = phase_sum >= {1'b0, rate_ext};
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r    <= lisr_pkg::PR_EMPTY;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        unique case (primed_r)
          lisr_pkg::PR_EMPTY: primed_r <= lisr_pkg::PR_ONE;
          lisr_pkg::PR_ONE:   primed_r <= lisr_pkg::PR_FULL;
          default:            phase_r  <= phase_sub;
        endcase
      end else if (cmd.emit) begin
        phase_r <= phase_sum[PW-1:0];
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      unique case (primed_r)
        lisr_pkg::PR_EMPTY: begin
          older_r_r <= in_right;
          older_l_r <= in_left;
        end
        lisr_pkg::PR_ONE: begin
          newer_r_r <= in_right;
          newer_l_r <= in_left;
        end
        default: begin
          older_r_r <= newer_r_r;
          older_l_r <= newer_l_r;
          newer_r_r <= in_right;
          newer_l_r <= in_left;
        end
      endcase
    end
    if (cmd.emit) begin
      out_left_r  <= lane_l;
      out_right_r <= lane_r;
      out_last_r  <= cmd.emit_last;
    end
  end

  lisr_lane u_lane_left (
    .clk     (clk),
    .mul_en  (cmd.mul),
    .step_en (cmd.div_step),
    .mute    (mute),
    .older   (older_l_r),
    .newer   (newer_l_r),
    .phase   (phase_r[RW-1:0]),
    .divisor (rate),
    .sample  (lane_l)
  );

  lisr_lane u_lane_right (
    .clk     (clk),
    .mul_en  (cmd.mul),
    .step_en (cmd.div_step),
    .mute    (mute),
    .older   (older_r_r),
    .newer   (newer_r_r),
    .phase   (phase_r[RW-1:0]),
    .divisor (rate),
    .sample  (lane_r)
  );

  assign out_valid = out_valid_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;
  assign out_last  = out_last_r;

endmodule

@@ rtl/lisr_ctrl.sv @@
// ----------------------------------------------------------------------------
// lisr_ctrl: resampler sequencer
// Takes one input item, then loops check / multiply / divide / emit until
// the phase reaches the rate or the per-item result cap is hit.
// ----------------------------------------------------------------------------
module lisr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lisr_pkg::sts_t sts,
  output lisr_pkg::cmd_t cmd
);

  localparam int CW = lisr_pkg::CNT_W;
  localparam int TW = lisr_pkg::STEP_W;

  lisr_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [TW-1:0]    step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lisr_pkg::ST_IDLE;
      cnt_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      lisr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          // first frame after reset only primes the pair
          state_nxt = sts.primed0 ? lisr_pkg::ST_IDLE : lisr_pkg::ST_CHECK;
        end
      end
      lisr_pkg::ST_CHECK: begin
        if (sts.more && cnt_r != CW'(lisr_pkg::MAX_RESULTS)) begin
          state_nxt = lisr_pkg::ST_MUL;
        end else begin
          state_nxt = lisr_pkg::ST_IDLE;
        end
      end
      lisr_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        step_nxt  = '0;
        state_nxt = lisr_pkg::ST_DIV;
      end
      lisr_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == TW'(lisr_pkg::SAMPLE_W - 1)) begin
          state_nxt = lisr_pkg::ST_EMIT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      lisr_pkg::ST_EMIT: begin
        // hold until the result register frees up
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = sts.last_hint ||
                          (cnt_r == CW'(lisr_pkg::MAX_RESULTS - 1));
          cnt_nxt       = cnt_r + 1'b1;
          state_nxt     = lisr_pkg::ST_CHECK;
        end
      end
      default: state_nxt = lisr_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ rtl/linear_interp_stereo_resampler.sv @@
// ----------------------------------------------------------------------------
// linear_interp_stereo_resampler: stereo linear-interpolation rate converter
// Usage:
//   in_*   : one source frame per item, taken when in_tvalid and in_tready.
//   out_*  : zero to six interpolated frames per input item, in order; tlast
//            marks the final frame caused by that input.
//   cfg_*  : register 0 output rate (clamped to 8000..192000), register 1
//            mute. Write only while the block is idle.
// Timing: the first frame after reset primes the pair and yields nothing.
//   Each result takes a check, a registered multiply, 16 steps
//   of each lane's restoring divider and the emit; both channels run
//   in parallel lanes.
//   Results sit in an output register; while the receiver stalls the
//   sequencer holds at the emit step, and in_tready stays low until the
//   item's last result has been written there.
// Reset: synchronous, active low; clears the frame priming, the phase, the
//   result valid flag and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module linear_interp_stereo_resampler #(
  parameter int SOURCE_RATE = lisr_pkg::SOURCE_RATE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // right_sample, left_sample
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // left_out, right_out
  output logic                           out_tlast,
  input  logic                           cfg_wr_en,
  input  logic [lisr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lisr_pkg::RATE_W-1:0]    cfg_wdata
);

  localparam int SW = lisr_pkg::SAMPLE_W;
  localparam int RW = lisr_pkg::RATE_W;

  logic [RW-1:0]   output_rate_r;
  logic            mute_r;
  logic [RW-1:0]   rate_eff;
  logic [SW-1:0]   out_left, out_right;
  lisr_pkg::cmd_t  cmd;
  lisr_pkg::sts_t  sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_rate_r <= RW'(lisr_pkg::RATE_RESET);
      mute_r        <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lisr_pkg::CFG_OUTPUT_RATE: output_rate_r <= cfg_wdata;
        lisr_pkg::CFG_MUTE:        mute_r        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (output_rate_r < RW'(lisr_pkg::RATE_MIN)) begin
      rate_eff = RW'(lisr_pkg::RATE_MIN);
    end else if (output_rate_r > RW'(lisr_pkg::RATE_MAX)) begin
      rate_eff = RW'(lisr_pkg::RATE_MAX);
    end else begin
      rate_eff = output_rate_r;
    end
  end

  lisr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lisr_dp #(
    .SOURCE_RATE (SOURCE_RATE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_right  (in_tdata[SW-1:0]),
    .in_left   (in_tdata[2*SW-1:SW]),
    .rate      (rate_eff),
    .mute      (mute_r),
    .out_ready (out_tready),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_left  (out_left),
    .out_right (out_right),
    .out_last  (out_tlast)
  );

  assign out_tdata = {out_right, out_left};

  // a result is only formed while the phase is still below the rate
  assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> sts.more)
    else $error("result emitted with phase at or above rate");

  // the result register is never overwritten while still unaccepted
  assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> sts.out_free)
    else $error("result register overwritten");

  // the priming frame produces no work, so the next item is taken at once
  assert property (@(posedge clk) disable iff (!rst_n)
                   (in_tvalid && in_tready && sts.primed0) |=> in_tready)
    else $error("priming frame started a run");

  // the input side stays closed while a run is in progress
  assert property (@(posedge clk) disable iff (!rst_n)
                   (cmd.mul || cmd.div_step || cmd.emit) |-> !in_tready)
    else $error("input accepted during a run");

endmodule
